FILE: rtl/ilr_pkg.sv
package ilr_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] RstPollTicks  = 16'd1200;
  localparam logic [7:0]  RstBusyLimit  = 8'd20;
  localparam logic [15:0] RstHalfPeriod = 16'd200;
  localparam logic [7:0]  RstMinToggles = 8'd10;
  localparam logic [7:0]  RstMaxToggles = 8'd50;

  localparam logic [1:0] OutcomeNone  = 2'd0;
  localparam logic [1:0] OutcomeFree  = 2'd1;
  localparam logic [1:0] OutcomeFault = 2'd2;

  typedef enum logic [2:0] {
    REG_POLL_TICKS   = 3'd0,
    REG_BUSY_LIMIT   = 3'd1,
    REG_HALF_PERIOD  = 3'd2,
    REG_MIN_TOGGLES  = 3'd3,
    REG_MAX_TOGGLES  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POLL      = 4'd1,
    PH_MIN_HIGH  = 4'd2,
    PH_MIN_LOW   = 4'd3,
    PH_EXT_HIGH  = 4'd4,
    PH_EXT_LOW   = 4'd5,
    PH_STOP_LOW  = 4'd6,
    PH_STOP_HIGH = 4'd7,
    PH_SETTLE    = 4'd8
  } phase_e;

  typedef struct packed {
    logic [15:0] poll_ticks;
    logic [7:0]  busy_retry_limit;
    logic [15:0] half_period_ticks;
    logic [7:0]  min_toggles;
    logic [7:0]  max_toggles;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic bus_busy;
    logic sda_sample;
  } item_t;

  typedef struct packed {
    logic       active;
    logic       pins_as_gpio;
    logic       scl_drive_en;
    logic       scl_level;
    logic       sda_drive_en;
    logic       sda_level;
    logic       done_res;
    logic [1:0] outcome;
  } result_t;

endpackage

FILE: rtl/ilr_stream_if.sv
interface ilr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/ilr_regs.sv
module ilr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ilr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ilr_pkg::CfgDataW-1:0]  pwdata,
  output logic [ilr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ilr_pkg::cfg_t                 cfg_o
);
  import ilr_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_POLL_TICKS:  cfg_d.poll_ticks        = pwdata[15:0];
        REG_BUSY_LIMIT:  cfg_d.busy_retry_limit  = pwdata[7:0];
        REG_HALF_PERIOD: cfg_d.half_period_ticks = pwdata[15:0];
        REG_MIN_TOGGLES: cfg_d.min_toggles       = pwdata[7:0];
        REG_MAX_TOGGLES: cfg_d.max_toggles       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLL_TICKS:  prdata = {16'd0, cfg_q.poll_ticks};
      REG_BUSY_LIMIT:  prdata = {24'd0, cfg_q.busy_retry_limit};
      REG_HALF_PERIOD: prdata = {16'd0, cfg_q.half_period_ticks};
      REG_MIN_TOGGLES: prdata = {24'd0, cfg_q.min_toggles};
      REG_MAX_TOGGLES: prdata = {24'd0, cfg_q.max_toggles};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_ticks        <= RstPollTicks;
      cfg_q.busy_retry_limit  <= RstBusyLimit;
      cfg_q.half_period_ticks <= RstHalfPeriod;
      cfg_q.min_toggles       <= RstMinToggles;
      cfg_q.max_toggles       <= RstMaxToggles;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/ilr_step.sv
module ilr_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ilr_pkg::item_t    item_i,
  input  ilr_pkg::cfg_t     cfg_i,
  output ilr_pkg::result_t  result_o
);
  import ilr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  retries_q, retries_d;
  logic [7:0]  toggles_q, toggles_d;
  logic        done;
  logic [1:0]  outcome;

  logic [15:0] limit;
  logic [16:0] tick_inc;
  logic        wait_hit;
  logic        pulse_last;
  logic [7:0]  toggles_dec;

  assign limit       = (phase_q == PH_POLL) ? cfg_i.poll_ticks : cfg_i.half_period_ticks;
  assign tick_inc    = {1'b0, tick_q} + 17'd1;
  assign wait_hit    = tick_inc >= {1'b0, limit};
  assign pulse_last  = toggles_q <= 8'd1;
  assign toggles_dec = pulse_last ? 8'd0 : toggles_q - 8'd1;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = wait_hit ? 16'd0 : tick_inc[15:0];
    retries_d = retries_q;
    toggles_d = toggles_q;
    done      = 1'b0;
    outcome   = OutcomeNone;
    case (phase_q)
      PH_IDLE: begin
        tick_d = tick_q;
        if (item_i.req_type) begin
          phase_d   = PH_POLL;
          tick_d    = 16'd0;
          retries_d = cfg_i.busy_retry_limit;
        end
      end
      PH_POLL: begin
        if (wait_hit) begin
          if (!item_i.bus_busy) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            outcome = OutcomeFree;
          end else if (retries_q <= 8'd1) begin
            retries_d = 8'd0;
            toggles_d = cfg_i.min_toggles;
            phase_d   = PH_MIN_HIGH;
          end else begin
            retries_d = retries_q - 8'd1;
          end
        end
      end
      PH_MIN_HIGH: begin
        if (wait_hit) phase_d = PH_MIN_LOW;
      end
      PH_MIN_LOW: begin
        if (wait_hit) begin
          if (pulse_last) begin
            toggles_d = cfg_i.max_toggles;
            phase_d   = PH_EXT_HIGH;
          end else begin
            toggles_d = toggles_dec;
            phase_d   = PH_MIN_HIGH;
          end
        end
      end
      PH_EXT_HIGH: begin
        if (wait_hit) phase_d = PH_EXT_LOW;
      end
      PH_EXT_LOW: begin
        if (wait_hit) begin
          toggles_d = toggles_dec;
          phase_d   = (item_i.sda_sample || pulse_last) ? PH_STOP_LOW : PH_EXT_HIGH;
        end
      end
      PH_STOP_LOW: begin
        if (wait_hit) phase_d = PH_STOP_HIGH;
      end
      PH_STOP_HIGH: begin
        if (wait_hit) phase_d = PH_SETTLE;
      end
      PH_SETTLE: begin
        if (wait_hit) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
          outcome = item_i.bus_busy ? OutcomeFault : OutcomeFree;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = 16'd0;
      end
    endcase
  end

  always_comb begin
    result_o.active       = phase_d != PH_IDLE;
    result_o.pins_as_gpio = phase_d inside {[PH_MIN_HIGH:PH_STOP_HIGH]};
    result_o.scl_drive_en = result_o.pins_as_gpio;
    result_o.scl_level    = phase_d inside {PH_MIN_HIGH, PH_EXT_HIGH, PH_STOP_LOW, PH_STOP_HIGH};
    result_o.sda_drive_en = phase_d inside {PH_STOP_LOW, PH_STOP_HIGH};
    result_o.sda_level    = phase_d == PH_STOP_HIGH;
    result_o.done_res     = done;
    result_o.outcome      = outcome;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= 16'd0;
      retries_q <= 8'd0;
      toggles_q <= 8'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      retries_q <= retries_d;
      toggles_q <= toggles_d;
    end
  end

endmodule

FILE: rtl/i2c_bus_lockup_recovery.sv
// I2C bus lockup check and bus-clear recovery. Each input beat is one timer tick carrying a
// start request flag and the sampled bus-busy and SDA levels; each tick yields exactly one
// result beat with the pin controls and, on the finishing tick, the outcome (free or lockup
// fault). One tick is taken per clock cycle while the result side does not stall; a tick's
// result passes through the input register, the sequencer update and the result register
// before it is offered. Timing and count registers are on the APB port; the user must write
// them only while no tick is in flight, and the block itself does not enforce this. Interval
// changes act at once, count changes at the next load of the count.
module i2c_bus_lockup_recovery (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ilr_stream_if.sink                    in_i,
  ilr_stream_if.source                  out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ilr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ilr_pkg::CfgDataW-1:0]  pwdata,
  output logic [ilr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ilr_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  result_t res;
  result_t out_q;
  logic    out_vld_q;
  logic    adv;

  ilr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ilr_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign adv           = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready    = ~in_vld_q | adv;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_q <= in_i.payload;
    if (adv) out_q <= res;
  end

endmodule
